FILE: rtl/aes_pkg.sv
// ============================================================================
// aes_pkg
// Shared types, tables and round functions for the AES-128 block cipher.
// ============================================================================
package aes_pkg;

    localparam int ROUND_COUNT_DEF = 10;
    localparam int KEY_WORDS_DEF   = 4 * (ROUND_COUNT_DEF + 1);
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 1'b1;

    localparam logic [7:0] GF_POLY = 8'h1b;

    typedef struct packed {
        logic        action;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_item_t;

    typedef enum logic [2:0] {
        KS_IDLE   = 3'b001,
        KS_EXPAND = 3'b010,
        KS_READY  = 3'b100
    } ks_state_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] sub_byte_rev(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1b;
            4'd9:    r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return a[7] ? ({a[6:0], 1'b0} ^ GF_POLY) : {a[6:0], 1'b0};
    endfunction

    // Byte b of 128-bit state: column b/4, row b%4, byte 0 at the top
    function automatic logic [7:0] st_byte(input logic [127:0] s, input int b);
        return s[127 - 8*b -: 8];
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int k = 0; k < 4; k++)
        begin
            a[k]  = c[31 - 8*k -: 8];
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            m9[k] = x8[k] ^ a[k];
            mb[k] = x8[k] ^ x2[k] ^ a[k];
            md[k] = x8[k] ^ x4[k] ^ a[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
        end
        return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

    // One encryption round after key addition: SubBytes, ShiftRows, MixColumns (MixColumns skipped when last is set)
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [127:0] t;
        logic [127:0] m;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 8*(4*c + r) -: 8] = sbox(st_byte(s, 4*((c + r) % 4) + r));
        for (int c = 0; c < 4; c++)
            m[127 - 32*c -: 32] = mix_col(t[127 - 32*c -: 32]);
        return last ? t : m;
    endfunction

    // Inverse ShiftRows and inverse SubBytes
    function automatic logic [127:0] dec_sub(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 8*(4*c + r) -: 8] = sub_byte_rev(st_byte(s, 4*((c + 4 - r) % 4) + r));
        return t;
    endfunction

    function automatic logic [127:0] dec_mix(input logic [127:0] s);
        logic [127:0] m;
        for (int c = 0; c < 4; c++)
            m[127 - 32*c -: 32] = inv_mix_col(s[127 - 32*c -: 32]);
        return m;
    endfunction

endpackage

FILE: rtl/aes128_block_cipher.sv
// ============================================================================
// aes128_block_cipher
// AES-128 encrypt/decrypt core with an eleven-stage round pipeline.
// ============================================================================
// Usage:
//   Write key_high (index 0) and key_low (index 1) through cfg_we/cfg_index/
//   cfg_data, only while no transaction is in flight. Every write restarts
//   a key expansion that fills 44 round-key words, one word a cycle; busy
//   is high in the write cycle and throughout the expansion after it.
//   A transaction (action, block_high, block_low in in_item) is taken at a
//   rising edge where start is high and busy is low.
//   Stage 0 adds round key 0 (encrypt) or 10 (decrypt), stages 1..10 run
//   one round each, so done pulses with out_item when the block reaches
//   stage 10. A new block can enter on every cycle outside key writes and
//   expansion: one block per cycle, set by the one round per pipeline stage.
//   Reset clears the valid bits and the expansion sequencer; the round keys
//   hold nothing valid until the first key write. The receiver cannot stall
//   the result, so the pipeline never holds.
// ============================================================================
module aes128_block_cipher #(
    parameter int ROUND_COUNT = aes_pkg::ROUND_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [aes_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [aes_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                start,
    input  aes_pkg::in_item_t                   in_item,
    output logic                                busy,
    output logic                                done,
    output aes_pkg::out_item_t                  out_item
);

    localparam int KEY_WORDS = 4 * (ROUND_COUNT + 1);
    localparam int KW_W      = $clog2(KEY_WORDS + 1);
    localparam int RK_W      = $clog2(ROUND_COUNT + 1);

    // ------------------------------------------------------------------
    // Key registers and expansion sequencer
    // ------------------------------------------------------------------
    logic [63:0]             key_high_reg, key_low_reg;
    aes_pkg::ks_state_t      ks_state_reg, ks_state_next;
    logic [KW_W-1:0]         ks_cnt_reg, ks_cnt_next;
    logic [31:0]             w_win_reg [4];
    logic [31:0]             w_new;
    logic [31:0]             w_t;
    logic [31:0]             w_key;
    logic [31:0]             w_word;
    logic [31:0]             rkey_reg [ROUND_COUNT+1][4];
    logic [127:0]            rkey_flat [ROUND_COUNT+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == aes_pkg::REG_KEY_HIGH)
                key_high_reg <= cfg_data;
            else
                key_low_reg <= cfg_data;
        end
    end

    // Compute next word from the sliding window of the last four; the first four come from the key
    always_comb
    begin
        w_t = w_win_reg[3];
        if (ks_cnt_reg[1:0] == 2'd0)
        begin
            w_t = {aes_pkg::sbox(w_win_reg[3][23:16]), aes_pkg::sbox(w_win_reg[3][15:8]),
                   aes_pkg::sbox(w_win_reg[3][7:0]), aes_pkg::sbox(w_win_reg[3][31:24])};
            w_t[31:24] = w_t[31:24] ^ aes_pkg::rcon(4'(ks_cnt_reg[KW_W-1:2] - 1'b1));
        end
        w_new = w_win_reg[0] ^ w_t;
        unique case (ks_cnt_reg[1:0])
            2'd0: w_key = key_high_reg[63:32];
            2'd1: w_key = key_high_reg[31:0];
            2'd2: w_key = key_low_reg[63:32];
            2'd3: w_key = key_low_reg[31:0];
        endcase
        w_word = (ks_cnt_reg < KW_W'(4)) ? w_key : w_new;
    end

    // Restart on every key write, stop after the last word
    always_comb
    begin
        ks_state_next = ks_state_reg;
        ks_cnt_next   = ks_cnt_reg;
        if (cfg_we)
        begin
            ks_state_next = aes_pkg::KS_EXPAND;
            ks_cnt_next   = '0;
        end
        else if (ks_state_reg == aes_pkg::KS_EXPAND)
        begin
            ks_cnt_next = ks_cnt_reg + 1'b1;
            if (ks_cnt_reg == KW_W'(KEY_WORDS - 1))
                ks_state_next = aes_pkg::KS_READY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ks_state_reg <= aes_pkg::KS_IDLE;
            ks_cnt_reg   <= '0;
        end
        else
        begin
            ks_state_reg <= ks_state_next;
            ks_cnt_reg   <= ks_cnt_next;
        end
    end

    // Shift the window and store each new word in its round key
    always_ff @(posedge clk)
    begin
        if (ks_state_reg == aes_pkg::KS_EXPAND)
        begin
            rkey_reg[ks_cnt_reg[RK_W+1:2]][ks_cnt_reg[1:0]] <= w_word;
            w_win_reg[3] <= w_word;
            w_win_reg[0] <= w_win_reg[1];
            w_win_reg[1] <= w_win_reg[2];
            w_win_reg[2] <= w_win_reg[3];
        end
    end

    // Gather each round key into one 128-bit word
    always_comb
    begin
        for (int r = 0; r <= ROUND_COUNT; r++)
            rkey_flat[r] = {rkey_reg[r][0], rkey_reg[r][1], rkey_reg[r][2], rkey_reg[r][3]};
    end

    // ------------------------------------------------------------------
    // Round pipeline: stage 0 adds key 0 or key N, stages 1..N run rounds
    // ------------------------------------------------------------------
    logic                    vld_reg [ROUND_COUNT+1];
    logic                    act_reg [ROUND_COUNT];
    logic [127:0]            st_reg  [ROUND_COUNT+1];
    logic [127:0]            st_next [ROUND_COUNT+1];

    always_comb
    begin
        st_next[0] = {in_item.block_high, in_item.block_low}
                     ^ (in_item.action ? rkey_flat[0] : rkey_flat[ROUND_COUNT]);
        for (int k = 1; k <= ROUND_COUNT; k++)
        begin
            if (act_reg[k-1])
                st_next[k] = aes_pkg::enc_round(st_reg[k-1], k == ROUND_COUNT) ^ rkey_flat[k];
            else if (k == ROUND_COUNT)
                st_next[k] = aes_pkg::dec_sub(st_reg[k-1]) ^ rkey_flat[0];
            else
                st_next[k] = aes_pkg::dec_mix(aes_pkg::dec_sub(st_reg[k-1])
                                              ^ rkey_flat[ROUND_COUNT - k]);
        end
    end

    // Advance the valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ROUND_COUNT; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int k = 1; k <= ROUND_COUNT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // Advance state and action through the stages
    always_ff @(posedge clk)
    begin
        st_reg[0]  <= st_next[0];
        act_reg[0] <= in_item.action;
        for (int k = 1; k <= ROUND_COUNT; k++)
            st_reg[k] <= st_next[k];
        for (int k = 1; k < ROUND_COUNT; k++)
            act_reg[k] <= act_reg[k-1];
    end

    assign busy     = (ks_state_reg == aes_pkg::KS_EXPAND) || cfg_we;
    assign done     = vld_reg[ROUND_COUNT];
    assign out_item = st_reg[ROUND_COUNT];

endmodule

FILE: rtl/aes_checker.sv
// ============================================================================
// aes_checker
// Port-level checks for the AES-128 block cipher, bound to the top level.
// ============================================================================
module aes_checker #(
    parameter int LATENCY = aes_pkg::ROUND_COUNT_DEF + 1
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_we
);

    // Every accepted transaction returns after the pipeline latency
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("no result for an accepted transaction");

    // A result only follows an accepted transaction
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("done without a matching transaction");

    // A key write keeps the block busy in the next cycle
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy)
        else $error("busy not raised after a key write");

    // Handshake outputs are always known out of reset
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({busy, done}))
        else $error("busy or done unknown");

endmodule

bind aes128_block_cipher aes_checker #(.LATENCY(ROUND_COUNT + 1)) u_aes_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cfg_we (cfg_we)
);

FILE: verif/aes128_block_cipher_checker.sv
// ============================================================================
// aes128_block_cipher_checker
// Watches the key port and both transaction channels of the AES-128 core,
// keeps its own key schedule, predicts every block and compares the results.
// ============================================================================
module aes128_block_cipher_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [aes_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [aes_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                start,
    input  aes_pkg::in_item_t                   in_item,
    input  logic                                busy,
    input  logic                                done,
    input  aes_pkg::out_item_t                  out_item,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  checked
);

    logic [7:0]          fwd_sub [256];
    logic [7:0]          rev_sub [256];
    logic [31:0]         sched [aes_pkg::KEY_WORDS_DEF];
    logic [63:0]         key_hi;
    logic [63:0]         key_lo;
    aes_pkg::out_item_t  expected_results [$];

    // GF(2^8) multiply, reduction by the AES polynomial
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= a;
            a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
        end
        return acc;
    endfunction

    // Build both substitution tables from the field inverse and affine map
    initial
    begin
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gf_mul(x[7:0], y[7:0]) == 8'h01)
                    inv = y[7:0];
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_sub[x] = s;
            rev_sub[s] = x[7:0];
        end
    end

    function automatic void expand_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        sched[0] = key_hi[63:32];
        sched[1] = key_hi[31:0];
        sched[2] = key_lo[63:32];
        sched[3] = key_lo[31:0];
        rc = 8'h01;
        for (int i = 4; i < aes_pkg::KEY_WORDS_DEF; i++)
        begin
            t = sched[i-1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]],
                     fwd_sub[t[7:0]]} ^ {rc, 24'h0};
                rc = gf_mul(rc, 8'h02);
            end
            sched[i] = sched[i-4] ^ t;
        end
    endfunction

    function automatic logic [127:0] add_round_key(input logic [127:0] s, input int k);
        return s ^ {sched[4*k], sched[4*k+1], sched[4*k+2], sched[4*k+3]};
    endfunction

    // Byte i of the state is column i/4, row i%4, byte 0 at the top
    function automatic logic [127:0] substitute(input logic [127:0] s, input bit inverse);
        logic [127:0] t;
        for (int i = 0; i < 16; i++)
            t[127-8*i -: 8] = inverse ? rev_sub[s[127-8*i -: 8]] : fwd_sub[s[127-8*i -: 8]];
        return t;
    endfunction

    function automatic logic [127:0] rotate_rows(input logic [127:0] s, input bit inverse);
        logic [127:0] t;
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                src = inverse ? ((c + 4 - r) % 4) : ((c + r) % 4);
                t[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
            end
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input bit inverse);
        logic [7:0]   coef [4];
        logic [7:0]   acc;
        logic [127:0] t;
        if (inverse)
            coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else
            coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++)
                    acc ^= gf_mul(s[127-8*(4*c+k) -: 8], coef[(k + 4 - r) % 4]);
                t[127-8*(4*c+r) -: 8] = acc;
            end
        return t;
    endfunction

    function automatic aes_pkg::out_item_t cipher_block(input aes_pkg::in_item_t item);
        logic [127:0] s;
        s = {item.block_high, item.block_low};
        if (item.action)
        begin
            s = add_round_key(s, 0);
            for (int rnd = 1; rnd <= aes_pkg::ROUND_COUNT_DEF; rnd++)
            begin
                s = rotate_rows(substitute(s, 1'b0), 1'b0);
                if (rnd < aes_pkg::ROUND_COUNT_DEF)
                    s = mix(s, 1'b0);
                s = add_round_key(s, rnd);
            end
        end
        else
        begin
            s = add_round_key(s, aes_pkg::ROUND_COUNT_DEF);
            for (int rnd = 1; rnd <= aes_pkg::ROUND_COUNT_DEF; rnd++)
            begin
                s = substitute(rotate_rows(s, 1'b1), 1'b1);
                s = add_round_key(s, aes_pkg::ROUND_COUNT_DEF - rnd);
                if (rnd < aes_pkg::ROUND_COUNT_DEF)
                    s = mix(s, 1'b1);
            end
        end
        return '{result_high: s[127:64], result_low: s[63:0]};
    endfunction

    // Track key writes, predict accepted blocks, compare finished ones
    always @(posedge clk or negedge rst_n)
    begin
        aes_pkg::out_item_t want;
        if (!rst_n)
        begin
            key_hi = '0;
            key_lo = '0;
            fail_count = 0;
            checked = 0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no block outstanding: %h %h",
                           out_item.result_high, out_item.result_low);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    if (out_item.result_high !== want.result_high)
                    begin
                        $error("result_high: expected %h, actual %h",
                               want.result_high, out_item.result_high);
                        fail_count++;
                    end
                    if (out_item.result_low !== want.result_low)
                    begin
                        $error("result_low: expected %h, actual %h",
                               want.result_low, out_item.result_low);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(cipher_block(in_item));
            if (cfg_we)
            begin
                if (cfg_index == aes_pkg::REG_KEY_HIGH)
                    key_hi = cfg_data;
                else
                    key_lo = cfg_data;
                expand_schedule();
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: verif/aes128_block_cipher_tb.sv
// ============================================================================
// aes128_block_cipher_tb
// Runs the AES-128 core through several keys: directed vectors, then random
// encrypt and decrypt blocks sent in bursts; the checker scores every result.
// ============================================================================
module aes128_block_cipher_tb;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [aes_pkg::CFG_INDEX_W-1:0]     cfg_index;
    logic [aes_pkg::CFG_DATA_W-1:0]      cfg_data;
    logic                                start;
    aes_pkg::in_item_t                   in_item;
    logic                                busy;
    logic                                done;
    aes_pkg::out_item_t                  out_item;
    int                                  fail_count;
    int                                  pending;
    int                                  checked;

    int burst_left;
    int enc_sent;
    int dec_sent;
    int key_settings;

    aes128_block_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .in_item   (in_item),
        .busy      (busy),
        .done      (done),
        .out_item  (out_item)
    );

    aes128_block_cipher_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .in_item    (in_item),
        .busy       (busy),
        .done       (done),
        .out_item   (out_item),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Guard against a hang
    initial
    begin
        #400000;
        $display("aes128_block_cipher test failed");
        $finish;
    end

    // Hold until every block is back, then let the core settle
    task automatic drain();
        start = 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write one key register while idle and wait out the expansion
    task automatic write_key(input logic [aes_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] value);
        drain();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        repeat (2) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
        write_key(aes_pkg::REG_KEY_HIGH, hi);
        write_key(aes_pkg::REG_KEY_LOW, lo);
        key_settings++;
    endtask

    // Present one transaction; keep start high inside a burst
    task automatic send_block(input logic act, input logic [63:0] hi, input logic [63:0] lo);
        start = 1'b1;
        in_item = '{action: act, block_high: hi, block_low: lo};
        while (busy)
            @(negedge clk);
        @(negedge clk);
        if (act)
            enc_sent++;
        else
            dec_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start = 1'b0;
            burst_left = $urandom_range(0, 8);
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    endtask

    function automatic logic [63:0] rand_half();
        unique case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_blocks(input int count);
        for (int i = 0; i < count; i++)
            send_block(1'($urandom_range(0, 1)), rand_half(), rand_half());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = aes_pkg::REG_KEY_HIGH;
        cfg_data = '0;
        start = 1'b0;
        in_item = '0;
        burst_left = 0;
        enc_sent = 0;
        dec_sent = 0;
        key_settings = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Standard test key and vector, both directions, extreme blocks
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1'b0, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(1'b1, '0, '0);
        send_block(1'b0, '0, '0);
        send_block(1'b1, '1, '1);
        send_block(1'b0, '1, '1);
        send_block(1'b1, '1, '0);
        send_block(1'b0, '0, '1);
        load_key('0, '0);
        send_block(1'b1, '0, '0);
        send_block(1'b0, '1, '1);
        load_key('1, '1);
        send_block(1'b1, '0, '1);
        send_block(1'b0, '1, '0);

        // Random keys, including updates of one half only
        random_blocks(80);
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase % 3)
                0: load_key({$urandom, $urandom}, {$urandom, $urandom});
                1:
                begin
                    write_key(aes_pkg::REG_KEY_LOW, {$urandom, $urandom});
                    key_settings++;
                end
                default:
                begin
                    write_key(aes_pkg::REG_KEY_HIGH, {$urandom, $urandom});
                    key_settings++;
                end
            endcase
            random_blocks(80);
        end

        drain();
        repeat (20) @(negedge clk);
        $display("Covered %0d key settings, %0d encrypt and %0d decrypt blocks, %0d checked.",
                 key_settings, enc_sent, dec_sent, checked);
        if (fail_count == 0)
            $display("aes128_block_cipher test passed");
        else
            $display("aes128_block_cipher test failed");
        $finish;
    end

endmodule
